/* hdl/isks_pkg.sv */
// Shared constants, codes and types of the insertion sort key store.
`default_nettype none

package isks_pkg;

    // Store geometry
    localparam int DEPTH     = 256;
    localparam int KEY_BITS  = 16;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Field widths on the stream ports
    localparam int KIND_BITS    = 2;
    localparam int KEY_IN_BITS  = 16;
    localparam int RANK_BITS    = 8;
    localparam int OUT_KEY_BITS = 16;
    localparam int OUT_CNT_BITS = 9;
    localparam int RCMP_BITS    = (CNT_BITS > RANK_BITS) ? CNT_BITS : RANK_BITS;

    localparam int S_TDATA_BITS = 24;
    localparam int S_TUSER_BITS = KIND_BITS;
    localparam int M_TDATA_BITS = 32;
    localparam int M_PAD_BITS   = M_TDATA_BITS - OUT_KEY_BITS - OUT_CNT_BITS - 1;

    // Item kinds
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WR,
        S_RD_DATA,
        S_PUSH
    } t_state;

    // Request from the sequencer to the key memory
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [KEY_BITS-1:0]  wdata;
        logic [ADDR_BITS-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* hdl/isks_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module isks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/isks_ctrl.sv */
// Sequencer, key compare unit and result register of the key store.
`default_nettype none

module isks_ctrl (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [isks_pkg::S_TDATA_BITS-1:0]     i_s_axis_tdata,
    input  wire logic [isks_pkg::S_TUSER_BITS-1:0]     i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic      [isks_pkg::M_TDATA_BITS-1:0]     o_m_axis_tdata,
    output isks_pkg::t_mem_req                         o_mem_req,
    input  wire logic [isks_pkg::KEY_BITS-1:0]         i_mem_rdata
);

    import isks_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [ADDR_BITS-1:0]  r_pos, n_pos;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [KEY_BITS-1:0]   r_res_key, n_res_key;
    logic                  r_res_err, n_res_err;
    logic                  r_out_valid, n_out_valid;
    logic [M_TDATA_BITS-1:0] r_out_data, n_out_data;

    logic [KIND_BITS-1:0]  w_kind;
    logic [KEY_BITS-1:0]   w_key;
    logic [RANK_BITS-1:0]  w_rank;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_rank_ok;
    logic                  w_less;
    logic                  w_slot_free;

    // Unpack the input beat
    assign w_kind = i_s_axis_tuser;
    assign w_key  = KEY_BITS'(i_s_axis_tdata[KEY_IN_BITS-1:0]);
    assign w_rank = i_s_axis_tdata[KEY_IN_BITS +: RANK_BITS];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Shared compare unit and status terms
    assign w_full      = (r_count == CNT_BITS'(DEPTH));
    assign w_rank_ok   = (RCMP_BITS'(w_rank) < RCMP_BITS'(r_count));
    assign w_less      = (r_key < i_mem_rdata);
    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_kind)
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_state = S_PUSH;
                            end else if (r_count == '0) begin
                                n_state = S_INS_WR;
                            end else begin
                                n_state = S_INS_CMP;
                            end
                        end
                        KIND_READ: begin
                            n_state = w_rank_ok ? S_RD_DATA : S_PUSH;
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                if (w_less) begin
                    n_state = (r_pos == ADDR_BITS'(1)) ? S_INS_WR : S_INS_CMP;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_INS_WR:  n_state = S_PUSH;
            S_RD_DATA: n_state = S_PUSH;
            S_PUSH: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        o_mem_req   = '0;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_res_key   = r_res_key;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // Drop the result once the sink takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = w_key;
                    n_res_key = '0;
                    n_res_err = 1'b0;
                    unique case (w_kind)
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_pos           = ADDR_BITS'(r_count);
                                o_mem_req.raddr = ADDR_BITS'(r_count - CNT_BITS'(1));
                            end
                        end
                        KIND_READ: begin
                            if (w_rank_ok) begin
                                o_mem_req.raddr = ADDR_BITS'(w_rank);
                            end else begin
                                n_res_err = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_pos;
                if (w_less) begin
                    // Shift the larger key up and fetch the next one down
                    o_mem_req.wdata = i_mem_rdata;
                    o_mem_req.raddr = r_pos - ADDR_BITS'(2);
                    n_pos           = r_pos - ADDR_BITS'(1);
                end else begin
                    o_mem_req.wdata = r_key;
                    n_count         = r_count + CNT_BITS'(1);
                end
            end
            S_INS_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_pos;
                o_mem_req.wdata = r_key;
                n_count         = r_count + CNT_BITS'(1);
            end
            S_RD_DATA: begin
                n_res_key = i_mem_rdata;
            end
            S_PUSH: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {M_PAD_BITS'(0), r_res_err,
                                   OUT_CNT_BITS'(r_count), OUT_KEY_BITS'(r_res_key)};
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_res_key  <= n_res_key;
        r_res_err  <= n_res_err;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("key count beyond store depth");

    // Compare step always has a key below the insert point
    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_pos != '0))
        else $error("compare step at position zero");

    // Count moves only by one insert or by a clear
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_BITS'(1)) || (r_count == '0)))
        else $error("key count jumped");

    // Writes come only from insert steps, at or below the count
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> ((r_state == S_INS_CMP) || (r_state == S_INS_WR)) &&
            (CNT_BITS'(r_pos) <= r_count))
        else $error("memory write outside an insert");

    // A result beat appears only from the push state
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_PUSH))
        else $error("result beat without push");

endmodule

`default_nettype wire

/* hdl/insertion_sort_key_store_core.sv */
// Top level of the insertion sort key store: stream ports, sequencer and key memory.
`default_nettype none

// Sorted key store of DEPTH 16-bit keys kept in ascending order in one RAM.
// Each input beat gives exactly one result beat. An insert walks down from the
// top of the stored run, one RAM read, compare and write per cycle, moving every
// larger key up one place; that key-by-key walk through the key RAM sets how long
// an insert takes. A read in range passes the read-data step and then the push
// step; a read beyond the count, an insert into a full store, a clear or an unused
// kind goes straight to the push step. The push step waits while the output
// register still holds a beat that the sink has not taken. The input is ready only
// between items; the finished result sits in an output register, so a new item is
// taken while that beat still waits for the sink. The key RAM needs no clearing
// pass after reset: only keys below the count are used.
module insertion_sort_key_store_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: key [15:0], rank [23:16]
    input  wire logic [isks_pkg::S_TDATA_BITS-1:0] i_s_axis_tdata,
    // tuser: kind [1:0] (0 insert, 1 read, 2 clear)
    input  wire logic [isks_pkg::S_TUSER_BITS-1:0] i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: read_key [15:0], stored_count [24:16], error [25], zero [31:26]
    output logic      [isks_pkg::M_TDATA_BITS-1:0] o_m_axis_tdata
);

    import isks_pkg::*;

    t_mem_req              w_mem_req;
    logic [KEY_BITS-1:0]   w_mem_rdata;

    // Sequencer and compare unit
    isks_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_mem_req       (w_mem_req),
        .i_mem_rdata     (w_mem_rdata)
    );

    // Sorted key memory
    isks_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_waddr (w_mem_req.waddr),
        .i_wdata (w_mem_req.wdata),
        .i_raddr (w_mem_req.raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire

/* test/insertion_sort_key_store_core_test.sv */
// Stream testbench for the insertion sort key store: directed rows, then random episodes.
`timescale 1ns / 1ps

module insertion_sort_key_store_core_test;

    import isks_pkg::*;

    // Kind code the block must ignore
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam int RUN_ITEMS  = 1300;
    localparam int SETTLE_CYC = 300;
    localparam int DIR_ROWS   = 24;

    typedef struct packed {
        logic [OUT_KEY_BITS-1:0] read_key;
        logic [OUT_CNT_BITS-1:0] stored_count;
        logic                    err_flag;
    } t_store_result;

    // One stimulus row; typed rows carry their expected beat
    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [KEY_IN_BITS-1:0]  key;
        logic [RANK_BITS-1:0]    rank;
        logic                    typed;
        logic [OUT_KEY_BITS-1:0] exp_key;
        logic [OUT_CNT_BITS-1:0] exp_count;
        logic                    exp_err;
    } t_directed_row;

    typedef enum int {
        KEYS_RANDOM,
        KEYS_NARROW,
        KEYS_RISING,
        KEYS_FALLING
    } t_key_pattern;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [S_TDATA_BITS-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_BITS-1:0] i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] o_m_axis_tdata;

    // Shadow of the sorted store
    logic [KEY_BITS-1:0] model_keys [DEPTH];
    int                  model_count = 0;

    t_store_result pending_results [$];
    int            mismatches = 0;
    int            items_offered = 0;
    int            full_runs = 0;
    bit            quiet_mode = 1'b0;

    t_directed_row directed_rows [DIR_ROWS] = '{
        '{KIND_READ,   16'h0000, 8'd0,   1'b1, 16'h0000, 9'd0, 1'b1},
        '{KIND_READ,   16'h0000, 8'd255, 1'b1, 16'h0000, 9'd0, 1'b1},
        '{KIND_CLEAR,  16'h0000, 8'd0,   1'b1, 16'h0000, 9'd0, 1'b0},
        '{KIND_UNUSED, 16'hFFFF, 8'd255, 1'b1, 16'h0000, 9'd0, 1'b0},
        '{KIND_INSERT, 16'hFFFF, 8'd0,   1'b1, 16'h0000, 9'd1, 1'b0},
        '{KIND_INSERT, 16'h0000, 8'd0,   1'b1, 16'h0000, 9'd2, 1'b0},
        '{KIND_INSERT, 16'h4000, 8'd0,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_INSERT, 16'h4000, 8'd0,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_INSERT, 16'h3FFF, 8'd255, 1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_INSERT, 16'h8000, 8'd0,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_INSERT, 16'hC000, 8'd0,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_READ,   16'h0000, 8'd0,   1'b1, 16'h0000, 9'd7, 1'b0},
        '{KIND_READ,   16'h0000, 8'd6,   1'b1, 16'hFFFF, 9'd7, 1'b0},
        '{KIND_READ,   16'h0000, 8'd7,   1'b1, 16'h0000, 9'd7, 1'b1},
        '{KIND_READ,   16'hFFFF, 8'd3,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_READ,   16'h0000, 8'd2,   1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_READ,   16'h0000, 8'd255, 1'b1, 16'h0000, 9'd7, 1'b1},
        '{KIND_UNUSED, 16'h1234, 8'd2,   1'b1, 16'h0000, 9'd7, 1'b0},
        '{KIND_CLEAR,  16'hAAAA, 8'h55,  1'b1, 16'h0000, 9'd0, 1'b0},
        '{KIND_READ,   16'h0000, 8'd0,   1'b1, 16'h0000, 9'd0, 1'b1},
        '{KIND_INSERT, 16'h5555, 8'hAA,  1'b0, 16'h0000, 9'd0, 1'b0},
        '{KIND_READ,   16'h0000, 8'd0,   1'b1, 16'h5555, 9'd1, 1'b0},
        '{KIND_CLEAR,  16'h0000, 8'd0,   1'b1, 16'h0000, 9'd0, 1'b0},
        '{KIND_UNUSED, 16'h0000, 8'd0,   1'b1, 16'h0000, 9'd0, 1'b0}
    };

    insertion_sort_key_store_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    // Apply one item to the shadow store and return the beat it must produce
    function automatic t_store_result apply_store_item(input logic [KIND_BITS-1:0] kind,
                                                       input logic [KEY_BITS-1:0] key,
                                                       input logic [RANK_BITS-1:0] rank);
        t_store_result res;
        int            pos;
        res = '0;
        case (kind)
            KIND_INSERT: begin
                if (model_count >= DEPTH) begin
                    res.err_flag = 1'b1;
                end else begin
                    // shift larger keys up; equal keys stay below the new one
                    pos = model_count;
                    while (pos > 0 && key < model_keys[pos-1]) begin
                        model_keys[pos] = model_keys[pos-1];
                        pos--;
                    end
                    model_keys[pos] = key;
                    model_count++;
                end
            end
            KIND_READ: begin
                if (int'(rank) < model_count) begin
                    res.read_key = model_keys[rank];
                end else begin
                    res.err_flag = 1'b1;
                end
            end
            KIND_CLEAR: begin
                model_count = 0;
            end
            default: ;
        endcase
        res.stored_count = model_count[OUT_CNT_BITS-1:0];
        return res;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one; no pause in quiet mode
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [KEY_BITS-1:0] next_key(input t_key_pattern pattern,
                                                     inout int running);
        case (pattern)
            KEYS_NARROW: begin
                // few distinct values so equal keys pile up
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h4000;
                    default: return 16'($urandom_range(0, 7));
                endcase
            end
            KEYS_RISING: begin
                running = running + $urandom_range(0, 300);
                if (running > 65535) running = 65535;
                return 16'(running);
            end
            KEYS_FALLING: begin
                running = running - $urandom_range(0, 300);
                if (running < 0) running = 0;
                return 16'(running);
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Drive one beat at the falling edge and hold it until the block takes it
    task automatic offer_item(input logic [KIND_BITS-1:0] kind,
                              input logic [KEY_IN_BITS-1:0] key,
                              input logic [RANK_BITS-1:0] rank,
                              input bit use_typed,
                              input t_store_result typed);
        int            gap;
        t_store_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {rank, key};
        i_s_axis_tuser  = kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_store_item(kind, key[KEY_BITS-1:0], rank);
        pending_results.push_back(use_typed ? typed : predicted);
        if (kind != KIND_UNUSED) items_offered++;
        @(negedge i_clk);
    endtask

    task automatic offer_read();
        int top;
        top = (model_count > 255) ? 255 : model_count;
        if ($urandom_range(0, 4) == 0) begin
            offer_item(KIND_READ, 16'($urandom), 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            offer_item(KIND_READ, 16'($urandom), 8'($urandom_range(0, top)), 1'b0, '0);
        end
    endtask

    // Hold off the sender until every expected beat has come back
    task automatic drain_results();
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // One fill of the store with mixed reads; a full run overflows it
    task automatic run_episode(input bit force_full);
        bit           to_full;
        int           target;
        int           n;
        int           r;
        int           running;
        t_key_pattern pattern;
        to_full = force_full || (full_runs < 2 && $urandom_range(0, 19) == 0);
        if (to_full) full_runs++;
        pattern = force_full ? KEYS_FALLING : t_key_pattern'($urandom_range(0, 3));
        running = (pattern == KEYS_RISING) ? $urandom_range(0, 2000)
                                           : $urandom_range(63000, 65535);
        target  = to_full ? DEPTH + $urandom_range(1, 4) : $urandom_range(1, 40);
        quiet_mode = ($urandom_range(0, 3) == 0);
        if (to_full || $urandom_range(0, 9) != 0) begin
            offer_item(KIND_CLEAR, 16'($urandom), 8'($urandom), 1'b0, '0);
        end
        n = 0;
        while (n < target) begin
            r = $urandom_range(0, 99);
            if (r < 60 || (to_full && r < 95)) begin
                offer_item(KIND_INSERT, next_key(pattern, running), 8'($urandom), 1'b0, '0);
                n++;
            end else if (r < 92) begin
                offer_read();
            end else if (r < 96 || to_full) begin
                offer_item(KIND_UNUSED, 16'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
                offer_item(KIND_CLEAR, 16'($urandom), 8'($urandom), 1'b0, '0);
            end
        end
        repeat ($urandom_range(1, 4)) offer_read();
        if (to_full) begin
            offer_item(KIND_READ, 16'h0000, 8'd255, 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0) drain_results();
    endtask

    // Sink pacing: random stalls, mostly short, a few long
    initial begin : sink_pacing
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                stall--;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                    : $urandom_range(1, 3);
                stall--;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_store_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result beat: tdata %h", o_m_axis_tdata);
                end
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[15:0] !== want.read_key
                        || o_m_axis_tdata[24:16] !== want.stored_count
                        || o_m_axis_tdata[25] !== want.err_flag
                        || o_m_axis_tdata[31:26] !== '0) begin
                    if (mismatches < 10) begin
                        $display("result mismatch: expected key %h count %0d err %b,%s%h",
                                 want.read_key, want.stored_count, want.err_flag,
                                 " got tdata ", o_m_axis_tdata);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows: empty store, extremes, equal keys, ignored kind
        for (int i = 0; i < DIR_ROWS; i++) begin
            offer_item(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].rank,
                       directed_rows[i].typed,
                       '{directed_rows[i].exp_key, directed_rows[i].exp_count,
                         directed_rows[i].exp_err});
        end

        // Wait out all results, then fill the store with falling keys and overflow it
        drain_results();
        run_episode(1'b1);

        while (items_offered < RUN_ITEMS) run_episode(1'b0);

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS insertion_sort_key_store_core");
        end else begin
            $display("FAIL insertion_sort_key_store_core");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("FAIL insertion_sort_key_store_core");
        $finish;
    end

endmodule

/* sim.f */
hdl/isks_pkg.sv
hdl/isks_ram.sv
hdl/isks_ctrl.sv
hdl/insertion_sort_key_store_core.sv
test/insertion_sort_key_store_core_test.sv
